@@ src/tts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tts_pkg;

  localparam int TASK_SLOTS_DEF   = 16;
  localparam int CANCEL_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF    = 32;
  localparam int MAX_RESULTS      = 16;
  localparam int ID_BITS          = 16;
  localparam int CNT_BITS         = 16;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED       = 3'd0,
    ST_TABLE_FULL  = 3'd1,
    ST_CANCEL_OK   = 3'd2,
    ST_CANCEL_DUP  = 3'd3,
    ST_CANCEL_FULL = 3'd4,
    ST_FIRED       = 3'd5,
    ST_NOTHING     = 3'd6
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [ID_BITS-1:0]  fired_id;
    logic                last;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_ACT,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

@@ src/tts_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Input side: registers one request into a single-entry holding stage.
module tts_front #(
  parameter int TIME_BITS = tts_pkg::TIME_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_op,
  input  wire logic [tts_pkg::ID_BITS-1:0]   in_id,
  input  wire logic [TIME_BITS-1:0]          in_expire,
  input  wire logic [TIME_BITS-1:0]          in_interval,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [tts_pkg::CNT_BITS-1:0]  in_count,
  input  wire logic [TIME_BITS-1:0]          in_now,
  output logic                               q_valid,
  input  wire logic                          q_take,
  output logic [1:0]                         q_op,
  output logic [tts_pkg::ID_BITS-1:0]        q_id,
  output logic [TIME_BITS-1:0]               q_expire,
  output logic [TIME_BITS-1:0]               q_interval,
  output logic [1:0]                         q_mode,
  output logic [tts_pkg::CNT_BITS-1:0]       q_count,
  output logic [TIME_BITS-1:0]               q_now
);

  assign in_ready = !q_valid || q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      q_op       <= in_op;
      q_id       <= in_id;
      q_expire   <= in_expire;
      q_interval <= in_interval;
      q_mode     <= in_mode;
      q_count    <= in_count;
      q_now      <= in_now;
    end
  end

endmodule
`default_nettype wire

@@ src/tts_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Executes requests against the task table and cancel set.
module tts_back #(
  parameter int TASK_SLOTS   = tts_pkg::TASK_SLOTS_DEF,
  parameter int CANCEL_SLOTS = tts_pkg::CANCEL_SLOTS_DEF,
  parameter int TIME_BITS    = tts_pkg::TIME_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  output logic                               q_take,
  input  wire logic [1:0]                    q_op,
  input  wire logic [tts_pkg::ID_BITS-1:0]   q_id,
  input  wire logic [TIME_BITS-1:0]          q_expire,
  input  wire logic [TIME_BITS-1:0]          q_interval,
  input  wire logic [1:0]                    q_mode,
  input  wire logic [tts_pkg::CNT_BITS-1:0]  q_count,
  input  wire logic [TIME_BITS-1:0]          q_now,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output tts_pkg::result_t                   res
);

  localparam int TW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = (CANCEL_SLOTS > 1) ? $clog2(CANCEL_SLOTS) : 1;
  localparam int NW = $clog2(tts_pkg::MAX_RESULTS + 1);

  logic [TASK_SLOTS-1:0]             slot_valid;
  logic [tts_pkg::ID_BITS-1:0]       slot_id       [TASK_SLOTS];
  logic [TIME_BITS-1:0]              slot_expiry   [TASK_SLOTS];
  logic [TIME_BITS-1:0]              slot_interval [TASK_SLOTS];
  logic [1:0]                        slot_mode     [TASK_SLOTS];
  logic [tts_pkg::CNT_BITS-1:0]      slot_runs_left[TASK_SLOTS];
  logic [CANCEL_SLOTS-1:0]           cancel_valid;
  logic [tts_pkg::ID_BITS-1:0]       cancel_id     [CANCEL_SLOTS];
  logic [TASK_SLOTS-1:0]             done;

  tts_pkg::state_t state, state_next;
  logic [TW:0]          scan_idx;
  logic                 have_best;
  logic [TW-1:0]        best;
  logic [TIME_BITS-1:0] best_exp;
  logic [NW-1:0]        n_fired;
  logic [tts_pkg::ID_BITS-1:0] held_id;

  // cancel lookup and free-slot searches are flat compares over the cancel set and task table
  logic                  c_hit;
  logic [CW-1:0]         c_idx;
  logic                  c_free;
  logic [CW-1:0]         c_free_idx;
  logic                  t_free;
  logic [TW-1:0]         t_free_idx;
  logic [tts_pkg::ID_BITS-1:0] look_id;

  assign look_id = (q_op == tts_pkg::OP_CANCEL) ? q_id : slot_id[best];

  always_comb begin
    c_hit = 1'b0; c_idx = '0; c_free = 1'b0; c_free_idx = '0;
    for (int i = CANCEL_SLOTS - 1; i >= 0; i--) begin
      if (cancel_valid[i] && cancel_id[i] == look_id) begin
        c_hit = 1'b1; c_idx = CW'(i);
      end
      if (!cancel_valid[i]) begin
        c_free = 1'b1; c_free_idx = CW'(i);
      end
    end
    t_free = 1'b0; t_free_idx = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        t_free = 1'b1; t_free_idx = TW'(i);
      end
    end
  end

  logic [TW-1:0]        sidx;
  logic                 s_due;
  logic [TIME_BITS:0]   resched;
  logic [TIME_BITS-1:0] resched_sat;
  logic                 keep;

  assign sidx  = scan_idx[TW-1:0];
  assign s_due = slot_valid[sidx] && !done[sidx] && (slot_expiry[sidx] <= q_now);
  assign resched = {1'b0, q_now} + {1'b0, slot_interval[best]};
  assign resched_sat = resched[TIME_BITS] ? '1 : resched[TIME_BITS-1:0];
  assign keep = slot_mode[best][0] ||
                (slot_mode[best][1] && slot_runs_left[best] > tts_pkg::CNT_BITS'(1));

  logic out_free;
  logic res_load;
  assign out_free = !res_valid || res_ready;
  // a fired result is sent one firing late, so the closing one can carry last
  assign res_load = out_free &&
                    ((state == tts_pkg::S_IDLE && q_valid && q_op != tts_pkg::OP_TICK) ||
                     (state == tts_pkg::S_ACT && n_fired != '0) ||
                     state == tts_pkg::S_DONE);

  always_comb begin
    state_next = state;
    unique case (state)
      tts_pkg::S_IDLE:  if (q_valid && out_free) begin
        state_next = (q_op == tts_pkg::OP_TICK) ? tts_pkg::S_SCAN : tts_pkg::S_IDLE;
      end
      tts_pkg::S_SCAN:  if (scan_idx == (TW+1)'(TASK_SLOTS - 1)) begin
        state_next = (have_best || s_due) ? tts_pkg::S_CHECK : tts_pkg::S_DONE;
      end
      tts_pkg::S_CHECK: state_next = c_hit ? tts_pkg::S_SCAN :
                          (n_fired == NW'(tts_pkg::MAX_RESULTS)) ? tts_pkg::S_DONE
                          : tts_pkg::S_ACT;
      tts_pkg::S_ACT:   if (out_free) state_next = tts_pkg::S_SCAN;
      tts_pkg::S_DONE:  if (out_free) state_next = tts_pkg::S_IDLE;
      default:          state_next = tts_pkg::S_IDLE;
    endcase
  end

  assign q_take = (state == tts_pkg::S_IDLE && q_valid && out_free &&
                   q_op != tts_pkg::OP_TICK) ||
                  (state == tts_pkg::S_DONE && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tts_pkg::S_IDLE;
      slot_valid <= '0;
      cancel_valid <= '0;
      res_valid <= 1'b0;
      done <= '0;
      n_fired <= '0;
      scan_idx <= '0;
      have_best <= 1'b0;
    end else begin
      state <= state_next;
      res_valid <= res_load || (res_valid && !res_ready);
      unique case (state)
        tts_pkg::S_IDLE: if (q_valid && out_free) begin
          done <= '0; n_fired <= '0; scan_idx <= '0; have_best <= 1'b0;
          unique case (tts_pkg::op_t'(q_op))
            tts_pkg::OP_ADD: begin
              res <= '{t_free ? tts_pkg::ST_ADDED : tts_pkg::ST_TABLE_FULL, q_id, 1'b1};
              if (t_free) begin
                slot_valid[t_free_idx]     <= 1'b1;
                slot_id[t_free_idx]        <= q_id;
                slot_expiry[t_free_idx]    <= q_expire;
                slot_interval[t_free_idx]  <= q_interval;
                slot_mode[t_free_idx]      <= q_mode;
                slot_runs_left[t_free_idx] <= q_count;
              end
            end
            tts_pkg::OP_CANCEL: begin
              if (c_hit) res <= '{tts_pkg::ST_CANCEL_DUP, q_id, 1'b1};
              else if (c_free) begin
                res <= '{tts_pkg::ST_CANCEL_OK, q_id, 1'b1};
                cancel_valid[c_free_idx] <= 1'b1;
                cancel_id[c_free_idx] <= q_id;
              end else res <= '{tts_pkg::ST_CANCEL_FULL, q_id, 1'b1};
            end
            tts_pkg::OP_CLEAR: begin
              res <= '{tts_pkg::ST_NOTHING, '0, 1'b1};
              slot_valid <= '0;
              cancel_valid <= '0;
            end
            tts_pkg::OP_TICK: ;
            default: ;
          endcase
        end
        tts_pkg::S_SCAN: begin
          if (s_due && (!have_best || slot_expiry[sidx] < best_exp)) begin
            have_best <= 1'b1; best <= sidx; best_exp <= slot_expiry[sidx];
          end
          if (scan_idx != (TW+1)'(TASK_SLOTS - 1)) scan_idx <= scan_idx + 1'b1;
        end
        tts_pkg::S_CHECK: begin
          scan_idx <= '0; have_best <= 1'b0;
          if (c_hit) begin
            cancel_valid[c_idx] <= 1'b0;
            slot_valid[best] <= 1'b0;
            done[best] <= 1'b1;
          end
        end
        tts_pkg::S_ACT: if (out_free) begin
          if (n_fired != '0) res <= '{tts_pkg::ST_FIRED, held_id, 1'b0};
          held_id <= slot_id[best];
          n_fired <= n_fired + 1'b1;
          done[best] <= 1'b1;
          if (keep) begin
            slot_expiry[best] <= resched_sat;
            if (slot_mode[best][1] && slot_runs_left[best] != '0)
              slot_runs_left[best] <= slot_runs_left[best] - 1'b1;
          end else begin
            slot_valid[best] <= 1'b0;
          end
        end
        tts_pkg::S_DONE: if (out_free) begin
          // closing result: the held firing, or nothing when none fired
          if (n_fired == '0) res <= '{tts_pkg::ST_NOTHING, '0, 1'b1};
          else res <= '{tts_pkg::ST_FIRED, held_id, 1'b1};
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    state == tts_pkg::S_ACT |-> have_best == 1'b0)
    else $error("act entered with live scan");
  assert property (@(posedge clk) disable iff (rst)
    n_fired <= NW'(tts_pkg::MAX_RESULTS))
    else $error("fire count overrun");
  assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid)
    else $error("take without request");

endmodule
`default_nettype wire

@@ src/tts_out.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Output stage: one register between the back end and the result port.
module tts_out (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              res_valid,
  output logic                   res_ready,
  input  wire tts_pkg::result_t  res,
  output logic                   m_valid,
  input  wire logic              m_ready,
  output tts_pkg::result_t       m_res
);

  logic m_free;

  assign m_free = !m_valid || m_ready;
  assign res_ready = m_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_free) begin
      m_valid <= res_valid;
      if (res_valid) m_res <= res;
    end
  end

endmodule
`default_nettype wire

@@ src/timer_task_scheduler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Add, cancel and clear: the result passes the back-end result register and
// the output register; one request per cycle while the result side keeps up.
// Tick: the back end scans all TASK_SLOTS slots for the earliest due task, then
// fires it or drops it if cancelled, and scans again; the next request is taken
// as the closing result is loaded, ahead of the output register.
// Synchronous reset empties the task table, cancel set and result stages.
module timer_task_scheduler #(
  parameter int TASK_SLOTS   = tts_pkg::TASK_SLOTS_DEF,
  parameter int CANCEL_SLOTS = tts_pkg::CANCEL_SLOTS_DEF,
  parameter int TIME_BITS    = tts_pkg::TIME_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // operation
  input  wire logic [1:0]   s_axis_tuser,
  // task id, expiry, interval, periodic, repeat, run count, current time,
  // zero pad
  input  wire logic [((34+3*TIME_BITS)+7)/8*8-1:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status
  output logic [2:0]        m_axis_tuser,
  // fired id
  output logic [15:0]       m_axis_tdata,
  output logic              m_axis_tlast
);

  localparam int T = TIME_BITS;

  logic q_valid, q_take;
  logic [1:0] q_op, q_mode;
  logic [15:0] q_id, q_count;
  logic [T-1:0] q_expire, q_interval, q_now;
  logic res_valid, res_ready;
  tts_pkg::result_t res, m_res;

  tts_front #(.TIME_BITS(T)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_op(s_axis_tuser), .in_id(s_axis_tdata[15:0]),
    .in_expire(s_axis_tdata[16+T-1:16]),
    .in_interval(s_axis_tdata[16+2*T-1:16+T]),
    .in_mode(s_axis_tdata[16+2*T+1:16+2*T]),
    .in_count(s_axis_tdata[18+2*T+15:18+2*T]),
    .in_now(s_axis_tdata[34+3*T-1:34+2*T]),
    .q_valid, .q_take, .q_op, .q_id, .q_expire, .q_interval,
    .q_mode, .q_count, .q_now
  );

  tts_back #(.TASK_SLOTS(TASK_SLOTS), .CANCEL_SLOTS(CANCEL_SLOTS),
             .TIME_BITS(T)) u_back (
    .clk, .rst, .q_valid, .q_take, .q_op, .q_id, .q_expire, .q_interval,
    .q_mode, .q_count, .q_now, .res_valid, .res_ready, .res
  );

  tts_out u_out (
    .clk, .rst, .res_valid, .res_ready, .res,
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_res
  );

  assign m_axis_tuser = m_res.status;
  assign m_axis_tdata = m_res.fired_id;
  assign m_axis_tlast = m_res.last;

endmodule
`default_nettype wire

@@ tb/timer_task_scheduler_tb.sv @@
`timescale 1ns / 1ps
module timer_task_scheduler_tb;

  localparam int SLOTS = 16;
  localparam int IN_W = ((34+3*32)+7)/8*8;
  localparam int IDLE_LIMIT = 6000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [1:0] s_axis_tuser = '0;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [2:0] m_axis_tuser;
  logic [15:0] m_axis_tdata;
  logic m_axis_tlast;

  always #6 clk = ~clk;

  timer_task_scheduler i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tuser(m_axis_tuser), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  // scheduler shadow state
  logic        tab_valid [SLOTS];
  logic [15:0] tab_id [SLOTS];
  logic [31:0] tab_expiry [SLOTS];
  logic [31:0] tab_interval [SLOTS];
  logic        tab_per [SLOTS];
  logic        tab_rep [SLOTS];
  logic [15:0] tab_runs [SLOTS];
  logic        cmark_valid [SLOTS];
  logic [15:0] cmark_id [SLOTS];

  tts_pkg::result_t pending_results[$];
  int mismatches = 0;
  bit quiet = 1'b0;
  int idle_cycles = 0;
  logic [31:0] clock_now = 0;

  function automatic void push_result(tts_pkg::status_t st, logic [15:0] id, logic lst);
    tts_pkg::result_t r;
    r.status = st;
    r.fired_id = id;
    r.last = lst;
    pending_results.push_back(r);
  endfunction

  function automatic int cancel_slot_of(logic [15:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (cmark_valid[i] && cmark_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void clear_schedule();
    for (int i = 0; i < SLOTS; i++) begin
      tab_valid[i] = 1'b0;
      cmark_valid[i] = 1'b0;
    end
  endfunction

  function automatic void run_tick(logic [31:0] now);
    bit done [SLOTS];
    int n;
    int best;
    int c;
    bit stop;
    logic [32:0] sum;
    n = 0;
    stop = 1'b0;
    for (int i = 0; i < SLOTS; i++) done[i] = 1'b0;
    while (!stop) begin
      best = -1;
      for (int i = 0; i < SLOTS; i++)
        if (tab_valid[i] && !done[i] && tab_expiry[i] <= now)
          if (best < 0 || tab_expiry[i] < tab_expiry[best]) best = i;
      if (best < 0) begin
        stop = 1'b1;
      end else begin
        c = cancel_slot_of(tab_id[best]);
        if (c >= 0) begin
          // cancelled task is dropped quietly and uses up its mark
          cmark_valid[c] = 1'b0;
          tab_valid[best] = 1'b0;
          done[best] = 1'b1;
        end else if (n >= tts_pkg::MAX_RESULTS) begin
          stop = 1'b1;
        end else begin
          done[best] = 1'b1;
          push_result(tts_pkg::ST_FIRED, tab_id[best], 1'b0);
          n++;
          if (tab_per[best] || (tab_rep[best] && tab_runs[best] > 1)) begin
            sum = {1'b0, now} + {1'b0, tab_interval[best]};
            tab_expiry[best] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (tab_rep[best] && tab_runs[best] > 0) tab_runs[best]--;
          end else begin
            tab_valid[best] = 1'b0;
          end
        end
      end
    end
    if (n == 0) push_result(tts_pkg::ST_NOTHING, 16'd0, 1'b1);
    else pending_results[pending_results.size()-1].last = 1'b1;
  endfunction

  function automatic void predict(tts_pkg::op_t op, logic [15:0] id, logic [31:0] expt,
                                  logic [31:0] iv, logic per, logic rep,
                                  logic [15:0] cnt, logic [31:0] now);
    int free_slot;
    free_slot = -1;
    case (op)
      tts_pkg::OP_ADD: begin
        for (int i = SLOTS - 1; i >= 0; i--) if (!tab_valid[i]) free_slot = i;
        if (free_slot < 0) begin
          push_result(tts_pkg::ST_TABLE_FULL, id, 1'b1);
        end else begin
          tab_valid[free_slot] = 1'b1;
          tab_id[free_slot] = id;
          tab_expiry[free_slot] = expt;
          tab_interval[free_slot] = iv;
          tab_per[free_slot] = per;
          tab_rep[free_slot] = rep;
          tab_runs[free_slot] = cnt;
          push_result(tts_pkg::ST_ADDED, id, 1'b1);
        end
      end
      tts_pkg::OP_CANCEL: begin
        if (cancel_slot_of(id) >= 0) begin
          push_result(tts_pkg::ST_CANCEL_DUP, id, 1'b1);
        end else begin
          for (int i = SLOTS - 1; i >= 0; i--) if (!cmark_valid[i]) free_slot = i;
          if (free_slot < 0) begin
            push_result(tts_pkg::ST_CANCEL_FULL, id, 1'b1);
          end else begin
            cmark_valid[free_slot] = 1'b1;
            cmark_id[free_slot] = id;
            push_result(tts_pkg::ST_CANCEL_OK, id, 1'b1);
          end
        end
      end
      tts_pkg::OP_TICK: run_tick(now);
      default: begin
        clear_schedule();
        push_result(tts_pkg::ST_NOTHING, 16'd0, 1'b1);
      end
    endcase
  endfunction

  task automatic send_request(tts_pkg::op_t op, logic [15:0] id, logic [31:0] expt,
                              logic [31:0] iv, logic per, logic rep,
                              logic [15:0] cnt, logic [31:0] now);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {6'd0, now, cnt, rep, per, iv, expt, id};
    do @(posedge clk); while (!s_axis_tready);
    predict(op, id, expt, iv, per, rep, cnt, now);
  endtask

  task automatic add_timer(logic [15:0] id, logic [31:0] expt, logic [31:0] iv,
                           logic per, logic rep, logic [15:0] cnt);
    send_request(tts_pkg::OP_ADD, id, expt, iv, per, rep, cnt, 32'd0);
  endtask

  task automatic tick_at(logic [31:0] now);
    send_request(tts_pkg::OP_TICK, 16'd0, 32'd0, 32'd0, 1'b0, 1'b0, 16'd0, now);
  endtask

  task automatic cancel_id(logic [15:0] id);
    send_request(tts_pkg::OP_CANCEL, id, 32'd0, 32'd0, 1'b0, 1'b0, 16'd0, 32'd0);
  endtask

  task automatic clear_all();
    send_request(tts_pkg::OP_CLEAR, 16'd0, 32'd0, 32'd0, 1'b0, 1'b0, 16'd0, 32'd0);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // basics: empty tick, extremes, cancel of an absent id, saturation, zero interval
  task automatic test_basic_ops();
    tick_at(32'd0);
    add_timer(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF);
    add_timer(16'h0000, 32'd0, 32'd0, 1'b1, 1'b0, 16'd0);
    add_timer(16'h1234, 32'd5, 32'd3, 1'b0, 1'b1, 16'd0);
    add_timer(16'h0042, 32'd5, 32'd2, 1'b0, 1'b1, 16'd3);
    cancel_id(16'hBEEF);
    cancel_id(16'hBEEF);
    add_timer(16'hBEEF, 32'd1, 32'd0, 1'b0, 1'b0, 16'd0);
    tick_at(32'd5);
    tick_at(32'd8);
    tick_at(32'hFFFF_FFF0);
    tick_at(32'hFFFF_FFFF);
    tick_at(32'hFFFF_FFFF);
    clear_all();
    tick_at(32'hFFFF_FFFF);
  endtask

  // table full, then ticks that drop a cancelled task and refire zero-interval tasks
  task automatic test_table_full();
    for (int i = 0; i < SLOTS; i++)
      add_timer(16'(i + 100), 32'(SLOTS - i), 32'd0, 1'b1, 1'b0, 16'd0);
    add_timer(16'h5555, 32'd0, 32'd0, 1'b0, 1'b0, 16'd0);
    cancel_id(16'd103);
    tick_at(32'd20);
    tick_at(32'd20);
    clear_all();
  endtask

  task automatic test_cancel_full();
    for (int i = 0; i <= SLOTS; i++) cancel_id(16'(i * 4099));
    cancel_id(16'd0);
    clear_all();
  endtask

  task automatic random_request();
    int sel;
    logic [15:0] id;
    logic [31:0] expt;
    logic [31:0] iv;
    logic [15:0] cnt;
    sel = $urandom_range(0, 99);
    id = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 11));
    if (sel < 40) begin
      expt = ($urandom_range(0, 9) == 0) ? $urandom : clock_now + $urandom_range(0, 40);
      case ($urandom_range(0, 5))
        0: iv = 32'd0;
        1: iv = $urandom;
        2: iv = 32'hFFFF_FFFF;
        default: iv = $urandom_range(1, 30);
      endcase
      cnt = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      add_timer(id, expt, iv, 1'($urandom), 1'($urandom), cnt);
    end else if (sel < 55) begin
      cancel_id(id);
    end else if (sel < 97) begin
      if ($urandom_range(0, 11) == 0) clock_now = $urandom;
      else clock_now = clock_now + $urandom_range(0, 25);
      tick_at(clock_now);
    end else begin
      clear_all();
    end
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 276; i++) begin
      if (i == 150) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
      if (i == 226) quiet = 1'b1;
      random_request();
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // receiver back-pressure in random bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tts_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result status=%0d id=%h last=%b",
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status || m_axis_tdata !== want.fired_id ||
            m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status=%0d id=%h last=%b, got status=%0d id=%h last=%b",
                     want.status, want.fired_id, want.last,
                     m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    clear_schedule();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_table_full();
    test_cancel_full();
    test_random_mix();
    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
